### hw/rtl/pva_pkg.sv
package pva_pkg;

	// Pool and timbre layout
	localparam int MAX_VOICES = 16;
	localparam int TIMBRES    = 4;
	localparam int VIDX_W     = $clog2(MAX_VOICES);
	localparam int VCNT_W     = $clog2(MAX_VOICES + 1);
	localparam int TIDX_W     = $clog2(TIMBRES + 1);

	// Configuration registers
	localparam int NREG        = 8;
	localparam int REGIDX_W    = 3;
	localparam int REG_W       = 5;
	localparam int REG_VOICES0 = 0;
	localparam int REG_SENSE0  = 4;

	// Field widths
	localparam int KIND_W   = 3;
	localparam int TIMBRE_W = 2;
	localparam int NOTE_W   = 7;
	localparam int VEL_W    = 7;
	localparam int VOICE_W  = 4;
	localparam int ACT_W    = 3;
	localparam int SVEL_W   = 8;
	localparam int AGE_W    = 32;

	// Velocity scaling and age search constants
	localparam int SENSE_FULL = 16;
	localparam int ZERO_STEP  = 8;
	localparam int VEL_SPAN   = 128;
	localparam int VEL_SHIFT  = $clog2(VEL_SPAN);
	localparam logic [AGE_W-1:0] AGE_LIMIT = 32'd2147483647;

	// Broadcast reporting cap
	localparam int OUT_CAP    = 16;
	localparam int REPORT_CNT = (MAX_VOICES < OUT_CAP) ? MAX_VOICES : OUT_CAP;

	// Command queue depth
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Event kinds
	localparam logic [KIND_W-1:0] KIND_NOTE_ON   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_NOTE_OFF  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FINISHED  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ALL_OFF   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_ALL_SOUND = 3'd4;

	// Result actions
	localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_START   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_RETRIG  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_KILL    = 3'd4;

	// Classified command handed from front to back
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [NOTE_W-1:0]  note;
		logic [SVEL_W-1:0]  svel;
		logic [VCNT_W-1:0]  lo;
		logic [VCNT_W-1:0]  hi;
		logic [VOICE_W-1:0] voice_in;
	} pva_cmd_t;

endpackage

### hw/rtl/pva_ifs.sv
// Note event channel
interface pva_evt_if;
	logic                            valid;
	logic                            ready;
	logic [pva_pkg::KIND_W-1:0]      kind;
	logic [pva_pkg::TIMBRE_W-1:0]    timbre;
	logic [pva_pkg::NOTE_W-1:0]      note;
	logic [pva_pkg::VEL_W-1:0]       velocity;
	logic [pva_pkg::VOICE_W-1:0]     voice_in;
	modport source(output valid, kind, timbre, note, velocity, voice_in, input ready);
	modport sink(input valid, kind, timbre, note, velocity, voice_in, output ready);
endinterface

// Voice action channel
interface pva_res_if;
	logic                            valid;
	logic                            ready;
	logic [pva_pkg::ACT_W-1:0]       action;
	logic [pva_pkg::VOICE_W-1:0]     voice_out;
	logic [pva_pkg::NOTE_W-1:0]      note_out;
	logic [pva_pkg::SVEL_W-1:0]      scaled_velocity;
	logic                            last;
	modport source(output valid, action, voice_out, note_out, scaled_velocity, last,
		input ready);
	modport sink(input valid, action, voice_out, note_out, scaled_velocity, last,
		output ready);
endinterface

// Register write channel
interface pva_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [pva_pkg::REGIDX_W-1:0]    index;
	logic [pva_pkg::REG_W-1:0]       data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### hw/rtl/pva_front.sv
module pva_front (
	input  logic              clk,
	input  logic              arst_n,
	pva_evt_if.sink           evt,
	pva_cfg_if.sink           cfg,
	output pva_pkg::pva_cmd_t q_cmd,
	output logic              q_push,
	input  logic              q_full
);
	import pva_pkg::*;

	localparam int SUM_W = ((VCNT_W > REG_W) ? VCNT_W : REG_W) + 1;
	localparam logic [REG_W-1:0] REG_RESET [NREG] = '{
		5'd5, 5'd1, 5'd1, 5'd1, 5'd16, 5'd16, 5'd16, 5'd16
	};

	logic [REG_W-1:0]        regs_q [NREG];
	logic [VCNT_W-1:0]       start [TIMBRES+1];
	logic [TIDX_W-1:0]       lo_idx;
	logic [TIDX_W-1:0]       hi_idx;
	logic [VCNT_W-1:0]       lo;
	logic [VCNT_W-1:0]       hi;
	logic [REG_W-1:0]        sense_raw;
	logic [REG_W-1:0]        sense;
	logic [SVEL_W-1:0]       zero;
	logic [SVEL_W-1:0]       span;
	logic [VEL_W+SVEL_W-1:0] prod;
	logic                    note_kind;
	logic                    keep;

	// Register file, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NREG; i++) regs_q[i] <= REG_RESET[i];
		end else if (cfg.valid && cfg.ready) begin
			regs_q[cfg.index] <= cfg.data;
		end
	end

	// Voice range starts, each clamped to the pool
	always_comb begin
		logic [SUM_W-1:0] sum;
		sum = '0;
		start[0] = '0;
		for (int t = 0; t < TIMBRES; t++) begin
			sum = SUM_W'(start[t]) + SUM_W'(regs_q[REG_VOICES0 + t]);
			start[t+1] = (sum > SUM_W'(MAX_VOICES)) ? VCNT_W'(MAX_VOICES) : VCNT_W'(sum);
		end
	end

	assign lo_idx = TIDX_W'(evt.timbre);
	assign hi_idx = lo_idx + TIDX_W'(1);
	assign lo     = start[lo_idx];
	assign hi     = start[hi_idx];

	// Velocity scaling: zero point rises as sensitivity drops
	assign sense_raw = regs_q[REGIDX_W'(REG_SENSE0) + REGIDX_W'(evt.timbre)];
	assign sense     = (sense_raw > REG_W'(SENSE_FULL)) ? REG_W'(SENSE_FULL) : sense_raw;
	assign zero      = SVEL_W'((SVEL_W'(SENSE_FULL) - SVEL_W'(sense)) * SVEL_W'(ZERO_STEP));
	assign span      = SVEL_W'(VEL_SPAN) - zero;
	assign prod      = (VEL_W+SVEL_W)'(evt.velocity) * (VEL_W+SVEL_W)'(span);

	// Drop items that cause nothing
	assign note_kind = (evt.kind == KIND_NOTE_ON) || (evt.kind == KIND_NOTE_OFF);
	assign keep = (note_kind && (32'(evt.timbre) < TIMBRES) && (lo < hi))
		|| (evt.kind == KIND_FINISHED) || (evt.kind == KIND_ALL_OFF)
		|| (evt.kind == KIND_ALL_SOUND);

	assign evt.ready = !q_full;
	assign q_push    = evt.valid && evt.ready && keep;

	assign q_cmd.kind     = evt.kind;
	assign q_cmd.note     = evt.note;
	assign q_cmd.svel     = zero + SVEL_W'(prod >> VEL_SHIFT);
	assign q_cmd.lo       = lo;
	assign q_cmd.hi       = hi;
	assign q_cmd.voice_in = evt.voice_in;

endmodule

### hw/rtl/pva_queue.sv
module pva_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  pva_pkg::pva_cmd_t wr_cmd,
	input  logic              push,
	output logic              full,
	output pva_pkg::pva_cmd_t rd_cmd,
	input  logic              pop,
	output logic              empty
);
	import pva_pkg::*;

	pva_cmd_t            ent_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_cmd  = ent_q[rd_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) ent_q[wr_q] <= wr_cmd;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			if (do_pop)  rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			if (do_push && !do_pop)      cnt_q <= cnt_q + QCNT_W'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

### hw/rtl/pva_back.sv
module pva_back (
	input  logic              clk,
	input  logic              arst_n,
	input  pva_pkg::pva_cmd_t cmd,
	input  logic              q_empty,
	output logic              q_pop,
	pva_res_if.source         res
);
	import pva_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ON   = 3'd1;
	localparam logic [2:0] ST_OLD  = 3'd2;
	localparam logic [2:0] ST_OFF  = 3'd3;
	localparam logic [2:0] ST_ALL  = 3'd4;

	// Voice state
	logic [NOTE_W-1:0]  vnote_q [MAX_VOICES];
	logic               vplay_q [MAX_VOICES];
	logic               vrel_q  [MAX_VOICES];
	logic [AGE_W-1:0]   vage_q  [MAX_VOICES];
	logic [AGE_W-1:0]   age_cnt_q;

	// Scan control
	logic [2:0]         state_q;
	logic [KIND_W-1:0]  kind_q;
	logic [NOTE_W-1:0]  note_q;
	logic [SVEL_W-1:0]  svel_q;
	logic [VCNT_W-1:0]  v_q;
	logic [VCNT_W-1:0]  lo_q;
	logic [VCNT_W-1:0]  hi_q;
	logic [AGE_W-1:0]   best_q;
	logic [VIDX_W-1:0]  pick_q;
	logic               found_q;

	// Output register
	logic               res_valid_q;
	logic [ACT_W-1:0]   act_q;
	logic [VOICE_W-1:0] vout_q;
	logic [NOTE_W-1:0]  nout_q;
	logic [SVEL_W-1:0]  rsvel_q;
	logic               last_q;

	logic               stall;
	logic [VIDX_W-1:0]  idx;
	logic               at_end;
	logic               match;
	logic               cand;
	logic [AGE_W-1:0]   best_n;
	logic [VIDX_W-1:0]  pick_n;
	logic               found_n;

	// Datapath decisions for this cycle
	logic               asg_en;
	logic [VIDX_W-1:0]  asg_idx;
	logic               emit_en;
	logic [ACT_W-1:0]   emit_act;
	logic [VIDX_W-1:0]  emit_idx;
	logic               emit_last;

	assign res.valid           = res_valid_q;
	assign res.action          = act_q;
	assign res.voice_out       = vout_q;
	assign res.note_out        = nout_q;
	assign res.scaled_velocity = rsvel_q;
	assign res.last            = last_q;

	assign stall  = res_valid_q && !res.ready;
	assign q_pop  = (state_q == ST_IDLE) && !q_empty && !stall;
	assign idx    = v_q[VIDX_W-1:0];
	assign at_end = (VCNT_W'(v_q + VCNT_W'(1)) == hi_q);
	assign match  = (vnote_q[idx] == note_q);

	// Oldest search: released voices in the first pass, all voices in the second
	assign cand    = ((state_q == ST_OLD) || vrel_q[idx]) && (vage_q[idx] < best_q);
	assign best_n  = cand ? vage_q[idx] : best_q;
	assign pick_n  = cand ? idx : pick_q;
	assign found_n = found_q || cand;

	always_comb begin
		asg_en    = 1'b0;
		asg_idx   = idx;
		emit_en   = 1'b0;
		emit_act  = ACT_NONE;
		emit_idx  = idx;
		emit_last = 1'b1;
		if (!stall) begin
			unique case (state_q)
				ST_ON: begin
					if (match || !vplay_q[idx]) begin
						asg_en   = 1'b1;
						emit_en  = 1'b1;
						emit_act = match ? ACT_RETRIG : ACT_START;
					end else if (at_end && found_n) begin
						asg_en   = 1'b1;
						asg_idx  = pick_n;
						emit_en  = 1'b1;
						emit_act = ACT_RETRIG;
						emit_idx = pick_n;
					end
				end
				ST_OLD: begin
					if (at_end) begin
						asg_en   = 1'b1;
						asg_idx  = pick_n;
						emit_en  = 1'b1;
						emit_act = ACT_RETRIG;
						emit_idx = pick_n;
					end
				end
				ST_OFF: begin
					if (match) begin
						emit_en  = 1'b1;
						emit_act = ACT_RELEASE;
					end
				end
				ST_ALL: begin
					emit_en   = (32'(v_q) < REPORT_CNT);
					emit_act  = (kind_q == KIND_ALL_OFF) ? ACT_RELEASE : ACT_KILL;
					emit_last = (v_q == VCNT_W'(REPORT_CNT - 1));
				end
				default: ;
			endcase
		end
	end

	// Voice state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_VOICES; i++) begin
				vnote_q[i] <= '0;
				vplay_q[i] <= 1'b0;
				vrel_q[i]  <= 1'b0;
				vage_q[i]  <= '0;
			end
			age_cnt_q <= '0;
		end else begin
			if (asg_en) begin
				vnote_q[asg_idx] <= note_q;
				vplay_q[asg_idx] <= 1'b1;
				vrel_q[asg_idx]  <= 1'b0;
				vage_q[asg_idx]  <= age_cnt_q;
				age_cnt_q        <= age_cnt_q + AGE_W'(1);
			end
			if (!stall && (state_q == ST_OFF) && match) vrel_q[idx] <= 1'b1;
			if (!stall && (state_q == ST_ALL)) begin
				if (kind_q == KIND_ALL_OFF) begin
					vrel_q[idx] <= 1'b1;
				end else begin
					vplay_q[idx] <= 1'b0;
					vrel_q[idx]  <= 1'b0;
				end
			end
			if (q_pop && (cmd.kind == KIND_FINISHED)
				&& (32'(cmd.voice_in) < MAX_VOICES)) begin
				vplay_q[VIDX_W'(cmd.voice_in)] <= 1'b0;
				vrel_q[VIDX_W'(cmd.voice_in)]  <= 1'b0;
			end
		end
	end

	// Scan sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_q     <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			kind_q  <= KIND_NOTE_ON;
			best_q  <= AGE_LIMIT;
			pick_q  <= '0;
			found_q <= 1'b0;
		end else if (!stall) begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						kind_q  <= cmd.kind;
						// broadcasts walk the whole pool from voice 0
						v_q     <= ((cmd.kind == KIND_ALL_OFF) || (cmd.kind == KIND_ALL_SOUND))
							? '0 : cmd.lo;
						lo_q    <= cmd.lo;
						hi_q    <= cmd.hi;
						best_q  <= AGE_LIMIT;
						pick_q  <= cmd.lo[VIDX_W-1:0];
						found_q <= 1'b0;
						unique case (cmd.kind)
							KIND_NOTE_ON:   state_q <= ST_ON;
							KIND_NOTE_OFF:  state_q <= ST_OFF;
							KIND_ALL_OFF,
							KIND_ALL_SOUND: state_q <= ST_ALL;
							default:        state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ON: begin
					if (match || !vplay_q[idx]) begin
						state_q <= ST_IDLE;
					end else if (at_end) begin
						if (found_n) begin
							state_q <= ST_IDLE;
						end else begin
							v_q     <= lo_q;
							state_q <= ST_OLD;
						end
					end else begin
						v_q     <= v_q + VCNT_W'(1);
						best_q  <= best_n;
						pick_q  <= pick_n;
						found_q <= found_n;
					end
				end
				ST_OLD: begin
					if (at_end) begin
						state_q <= ST_IDLE;
					end else begin
						v_q    <= v_q + VCNT_W'(1);
						best_q <= best_n;
						pick_q <= pick_n;
					end
				end
				ST_OFF: begin
					if (match || at_end) state_q <= ST_IDLE;
					else                 v_q <= v_q + VCNT_W'(1);
				end
				ST_ALL: begin
					if (v_q == VCNT_W'(MAX_VOICES - 1)) state_q <= ST_IDLE;
					else                                 v_q <= v_q + VCNT_W'(1);
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Note and velocity latched at dispatch
	always_ff @(posedge clk) begin
		if (q_pop) begin
			note_q <= cmd.note;
			svel_q <= cmd.svel;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_en) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			act_q   <= emit_act;
			vout_q  <= VOICE_W'(emit_idx);
			last_q  <= emit_last;
			if (emit_act == ACT_START || emit_act == ACT_RETRIG) begin
				nout_q  <= note_q;
				rsvel_q <= svel_q;
			end else begin
				nout_q  <= '0;
				rsvel_q <= '0;
			end
		end
	end

endmodule

### hw/rtl/polyphonic_voice_allocator.sv
// Polyphonic voice allocator: note events enter on evt, voice actions leave on res, and the
// eight 5-bit registers (voice counts of timbres 0..3, then velocity sensitivities 0..3) are
// written on cfg, which is always ready. The front classifies an item in the cycle it is
// taken and parks it in a two-entry command queue, so evt keeps accepting while the back
// is busy or a result waits, until two items are queued. The back owns the voice state; it
// takes a command from the queue, then reads one voice per cycle while not stalled: a
// note-on on a timbre of N voices scans up to N voices, plus up to N more when no voice is
// idle, matching or released and the oldest voice must be found; a note-off scans up to N
// voices; all-notes-off and all-sound-off walk all 16 voices and give one result for each;
// voice-finished is applied as it leaves the queue and gives nothing. A note-on or note-off
// yields at most one result, always with last set. Results are held in an output register
// and the back stalls while it is full and not taken.
module polyphonic_voice_allocator (
	input  logic      clk,
	input  logic      arst_n,
	pva_evt_if.sink   evt,
	pva_cfg_if.sink   cfg,
	pva_res_if.source res
);
	import pva_pkg::*;

	pva_cmd_t push_cmd;
	pva_cmd_t pop_cmd;
	logic     q_push;
	logic     q_full;
	logic     q_pop;
	logic     q_empty;

	pva_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt),
		.cfg    (cfg),
		.q_cmd  (push_cmd),
		.q_push (q_push),
		.q_full (q_full)
	);

	pva_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_cmd (push_cmd),
		.push   (q_push),
		.full   (q_full),
		.rd_cmd (pop_cmd),
		.pop    (q_pop),
		.empty  (q_empty)
	);

	pva_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (pop_cmd),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.res     (res)
	);

	// Front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("command queue overflow");

	// Back dispatches only queued commands
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command queue underflow");

	// Every result carries a real action
	a_action_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.action != ACT_NONE))
		else $error("result without action");

	// A note-on result is always the final result of its item
	a_note_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.action == ACT_START || res.action == ACT_RETRIG)) |-> res.last)
		else $error("note-on result without last");

endmodule
